@@ hw/rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Operation codes, register indexes, the command that travels from the front
// end to the back end, and the cell format.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;
   localparam int DEF_BUFFER_ROWS    = 64;

   localparam int OP_W       = 3;
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int ADDR_W     = 11;
   localparam int CURSOR_W   = 13;
   localparam int VIEW_W     = 6;
   localparam int CELL_W     = 16;
   localparam int COLOR_W    = 4;
   localparam int CSR_IDX_W  = 2;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_PUT_CHAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
   localparam logic [OP_W-1:0] OP_FLUSH     = 3'd3;
   localparam logic [OP_W-1:0] OP_READ      = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 2'd1;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_FG     = 4'd15;
   localparam logic [COLOR_W-1:0] RESET_BG     = 4'd0;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_PUT,
      KIND_BACKSPACE,
      KIND_CLEAR,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CHAR_W-1:0]   char_code;
      logic [COUNT_W-1:0]  erase_count;
      logic [ADDR_W-1:0]   cell_address;
   } cmd_type;

   function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] bg,
                                                   input logic [COLOR_W-1:0] fg,
                                                   input logic [CHAR_W-1:0] ch);
      return {bg, fg, ch};
   endfunction

endpackage

@@ hw/rtl/text_console_writer_with_scrollback.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_with_scrollback: text console engine with scrollback
// Each request beat carries an operation (put character, backspace, clear,
// flush or screen read) and returns exactly one response beat with the cursor,
// the first visible buffer row and, for a read, the displayed screen cell.
// The csr port sets the foreground and background colors between commands.
// Requests enter a two-entry command queue; the engine runs one command at a
// time and holds its response in an output register, so the queue keeps
// taking beats while a response waits under rsp_stall.
// A scroll blanks the recycled buffer row, a backspace erases up to
// erase_count+1 cells, a refresh copies each dirty screen row from the
// scrollback, and a clear sweeps the scrollback; these sweeps handle one
// cell per cycle.
// After reset the engine blanks the scrollback and zeros the screen memory in
// the same sweep that a clear runs; req_stall stays high during the pass,
// while csr writes are taken.
// ----------------------------------------------------------------------------
module text_console_writer_with_scrollback #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
   parameter int BUFFER_ROWS    = tcw_pkg::DEF_BUFFER_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]    csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tcw_pkg::OP_W-1:0]       req_operation,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [tcw_pkg::COUNT_W-1:0]    req_erase_count,
   input  logic [tcw_pkg::ADDR_W-1:0]     req_cell_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tcw_pkg::CURSOR_W-1:0]   rsp_cursor_position,
   output logic [tcw_pkg::VIEW_W-1:0]     rsp_view_offset,
   output logic [tcw_pkg::CELL_W-1:0]     rsp_cell_value
);
   import tcw_pkg::*;

   cmd_type push_data, head;
   logic    q_push, q_pop, q_full, q_empty, init_busy;

   tcw_front #(
      .SCREEN_CELLS(SCREEN_COLUMNS * SCREEN_ROWS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_char_code    (req_char_code),
      .req_erase_count  (req_erase_count),
      .req_cell_address (req_cell_address),
      .q_full           (q_full),
      .init_busy        (init_busy),
      .q_push           (q_push),
      .q_data           (push_data)
   );

   tcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   tcw_back #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .BUFFER_ROWS    (BUFFER_ROWS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .q_empty             (q_empty),
      .q_head              (head),
      .q_pop               (q_pop),
      .init_busy           (init_busy),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_view_offset     (rsp_view_offset),
      .rsp_cell_value      (rsp_cell_value)
   );

   a_init_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> req_stall)
      else $error("request taken during the clearing pass");

   a_full_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      q_full |-> req_stall)
      else $error("request taken while the command queue is full");

   a_view_in_buffer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_view_offset) < BUFFER_ROWS)
      else $error("view offset beyond the scrollback");

   a_cursor_in_buffer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor_position) < SCREEN_COLUMNS * BUFFER_ROWS)
      else $error("cursor beyond the scrollback");

endmodule

@@ hw/rtl/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front: request intake
// Accepts request beats, classifies the operation into a command and pushes
// it into the command queue.
// ----------------------------------------------------------------------------
module tcw_front #(
   parameter int SCREEN_CELLS = tcw_pkg::DEF_SCREEN_COLUMNS * tcw_pkg::DEF_SCREEN_ROWS
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tcw_pkg::OP_W-1:0]     req_operation,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::COUNT_W-1:0]  req_erase_count,
   input  logic [tcw_pkg::ADDR_W-1:0]   req_cell_address,
   input  logic                         q_full,
   input  logic                         init_busy,
   output logic                         q_push,
   output tcw_pkg::cmd_type             q_data
);
   import tcw_pkg::*;

   kind_type kind;

   always_comb begin
      unique case (req_operation)
         OP_PUT_CHAR:  kind = KIND_PUT;
         OP_BACKSPACE: kind = KIND_BACKSPACE;
         OP_CLEAR:     kind = KIND_CLEAR;
         OP_FLUSH:     kind = KIND_NONE;
         OP_READ:      kind = (32'(req_cell_address) < SCREEN_CELLS) ? KIND_READ : KIND_NONE;
         default:      kind = KIND_NONE;
      endcase
   end

   assign req_stall = q_full || init_busy;
   assign q_push    = req_valid && !req_stall;

   assign q_data.kind         = kind;
   assign q_data.char_code    = req_char_code;
   assign q_data.erase_count  = req_erase_count;
   assign q_data.cell_address = req_cell_address;

endmodule

@@ hw/rtl/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue: command queue
// A short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_data,
   input  logic             pop,
   output tcw_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import tcw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back: command execution engine
// Holds the scrollback memory as a ring of rows, the screen memory, cursor,
// view and dirty marks, and runs each command as a sequence of cell steps.
// ----------------------------------------------------------------------------
module tcw_back #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
   parameter int BUFFER_ROWS    = tcw_pkg::DEF_BUFFER_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]    csr_write_data,
   input  logic                           q_empty,
   input  tcw_pkg::cmd_type               q_head,
   output logic                           q_pop,
   output logic                           init_busy,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tcw_pkg::CURSOR_W-1:0]   rsp_cursor_position,
   output logic [tcw_pkg::VIEW_W-1:0]     rsp_view_offset,
   output logic [tcw_pkg::CELL_W-1:0]     rsp_cell_value
);
   import tcw_pkg::*;

   localparam int COL_W     = $clog2(SCREEN_COLUMNS);
   localparam int ROW_W     = $clog2(BUFFER_ROWS);
   localparam int SR_W      = $clog2(SCREEN_ROWS);
   localparam int RX_W      = ((ROW_W > SR_W) ? ROW_W : SR_W) + 1;
   localparam int LX_W      = RX_W + 1;
   localparam int BUF_AW    = ROW_W + COL_W;
   localparam int BUF_DEPTH = BUFFER_ROWS * (2 ** COL_W);
   localparam int SCR_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int SCR_AW    = $clog2(SCR_CELLS);
   localparam int SWEEP_LEN = (BUF_DEPTH > SCR_CELLS) ? BUF_DEPTH : SCR_CELLS;
   localparam int SWEEP_W   = $clog2(SWEEP_LEN);

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_FETCH,
      ST_PUT,
      ST_SCROLL,
      ST_BS_START,
      ST_BS_LOOP,
      ST_BS_END,
      ST_REF_ROW,
      ST_REF_COPY,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [COLOR_W-1:0]     fg_ff, fg_in, bg_ff, bg_in;
   logic [ROW_W-1:0]       cur_row_ff, cur_row_in;
   logic [COL_W-1:0]       cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]       fvr_ff, fvr_in;
   logic [ROW_W-1:0]       base_ff, base_in;
   logic [SCREEN_ROWS-1:0] dirty_ff, dirty_in;
   logic                   pend_ff, pend_in;
   logic                   init_ff, init_in;
   logic [SWEEP_W-1:0]     sweep_ff, sweep_in;
   logic [CELL_W-1:0]      sweep_val_ff, sweep_val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   copy_en_ff, copy_en_in;

   cmd_type                cmd_ff, cmd_in;
   logic [ROW_W-1:0]       old_row_ff, old_row_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       src_row_ff, src_row_in;
   logic                   src_ok_ff, src_ok_in;
   logic [SR_W-1:0]        ref_row_ff, ref_row_in;
   logic [SCR_AW-1:0]      scr_base_ff, scr_base_in;
   logic [CELL_W-1:0]      value_ff, value_in;
   logic [SCR_AW-1:0]      copy_addr_ff, copy_addr_in;
   logic                   copy_zero_ff, copy_zero_in;
   logic [CURSOR_W-1:0]    rsp_cursor_ff, rsp_cursor_in;
   logic [VIEW_W-1:0]      rsp_view_ff, rsp_view_in;
   logic [CELL_W-1:0]      rsp_cell_ff, rsp_cell_in;

   logic [CELL_W-1:0]      buf_mem [BUF_DEPTH];
   logic [CELL_W-1:0]      buf_rdata_ff;
   logic [CELL_W-1:0]      scr_mem [SCR_CELLS];
   logic [CELL_W-1:0]      scr_rdata_ff;

   logic                   buf_we;
   logic [BUF_AW-1:0]      buf_waddr;
   logic [CELL_W-1:0]      buf_wdata;
   logic [BUF_AW-1:0]      buf_raddr;
   logic                   scr_we;
   logic [SCR_AW-1:0]      scr_waddr;
   logic [CELL_W-1:0]      scr_wdata;
   logic [SCR_AW-1:0]      scr_raddr;

   logic                   out_free;
   logic [CELL_W-1:0]      blank_cell;
   logic                   is_newline, last_col, advance, shift, follow, cur_zero;
   logic [RX_W-1:0]        old_x, new_x;
   logic [LX_W-1:0]        line_x, fvr_sum, fvr_follow;
   logic [ROW_W-1:0]       fvr1;
   logic [SCREEN_ROWS-1:0] put_mask, cur_mask, end_mask;
   logic                   put_pend, end_pend;
   logic [ROW_W-1:0]       dec_row;
   logic [COL_W-1:0]       dec_col;
   logic                   ref_last;
   logic [LX_W-1:0]        src_x;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] b);
      logic [ROW_W:0] sum;
      sum = {1'b0, r} + {1'b0, b};
      if (sum >= (ROW_W + 1)'(BUFFER_ROWS)) begin
         sum = sum - (ROW_W + 1)'(BUFFER_ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [SCREEN_ROWS-1:0] row_mask(input logic [RX_W-1:0] row,
                                                       input logic [ROW_W-1:0] top);
      logic [RX_W-1:0]        d;
      logic [SCREEN_ROWS-1:0] m;
      d = row - RX_W'(top);
      m = '0;
      if (row >= RX_W'(top) && d < RX_W'(SCREEN_ROWS)) begin
         m[d[SR_W-1:0]] = 1'b1;
      end
      return m;
   endfunction

   assign blank_cell = make_cell(bg_ff, fg_ff, SPACE_CODE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign init_busy  = init_ff;

   assign is_newline = cmd_ff.char_code == NEWLINE_CODE;
   assign last_col   = cur_col_ff == COL_W'(SCREEN_COLUMNS - 1);
   assign advance    = is_newline || last_col;
   assign old_x      = RX_W'(cur_row_ff);
   assign new_x      = old_x + RX_W'(advance);
   assign put_mask   = row_mask(old_x, fvr_ff) | (advance ? row_mask(new_x, fvr_ff) : '0);
   assign shift      = advance && (cur_row_ff == ROW_W'(BUFFER_ROWS - 1));
   assign line_x     = shift ? LX_W'(old_x) : LX_W'(new_x);
   assign fvr1       = (shift && fvr_ff != '0) ? fvr_ff - 1'b1 : fvr_ff;
   assign fvr_sum    = LX_W'(fvr1) + LX_W'(SCREEN_ROWS);
   assign follow     = line_x >= fvr_sum;
   assign fvr_follow = line_x - LX_W'(SCREEN_ROWS) + LX_W'(1);
   assign put_pend   = pend_ff || (|put_mask) || shift || follow;

   assign cur_zero   = (cur_row_ff == '0) && (cur_col_ff == '0);
   assign dec_row    = (cur_col_ff == '0) ? cur_row_ff - 1'b1 : cur_row_ff;
   assign dec_col    = (cur_col_ff == '0) ? COL_W'(SCREEN_COLUMNS - 1) : cur_col_ff - 1'b1;
   assign cur_mask   = row_mask(RX_W'(cur_row_ff), fvr_ff);
   assign end_mask   = row_mask(RX_W'(old_row_ff), fvr_ff) | cur_mask;
   assign end_pend   = pend_ff || (|end_mask);

   assign ref_last   = ref_row_ff == SR_W'(SCREEN_ROWS - 1);
   assign src_x      = LX_W'(fvr_ff) + LX_W'(ref_row_ff);

   always_comb begin
      state_in     = state_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      fvr_in       = fvr_ff;
      base_in      = base_ff;
      dirty_in     = dirty_ff;
      pend_in      = pend_ff;
      init_in      = init_ff;
      sweep_in     = sweep_ff;
      sweep_val_in = sweep_val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      copy_en_in   = 1'b0;
      cmd_in       = cmd_ff;
      old_row_in   = old_row_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      src_row_in   = src_row_ff;
      src_ok_in    = src_ok_ff;
      ref_row_in   = ref_row_ff;
      scr_base_in  = scr_base_ff;
      value_in     = value_ff;
      copy_addr_in = scr_base_ff + SCR_AW'(col_ff);
      copy_zero_in = !src_ok_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_view_in   = rsp_view_ff;
      rsp_cell_in   = rsp_cell_ff;
      q_pop        = 1'b0;
      buf_we       = 1'b0;
      buf_waddr    = {cur_row_ff, cur_col_ff};
      buf_wdata    = blank_cell;
      buf_raddr    = {src_row_ff, col_ff};
      scr_raddr    = SCR_AW'(q_head.cell_address);
      scr_we       = copy_en_ff;
      scr_waddr    = copy_addr_ff;
      scr_wdata    = copy_zero_ff ? '0 : buf_rdata_ff;

      if (csr_write_enable) begin
         if (csr_index == CSR_FOREGROUND) begin
            fg_in = csr_write_data;
         end else if (csr_index == CSR_BACKGROUND) begin
            bg_in = csr_write_data;
         end
      end

      unique case (state_ff)
         ST_SWEEP: begin
            if (32'(sweep_ff) < BUF_DEPTH) begin
               buf_we    = 1'b1;
               buf_waddr = sweep_ff[BUF_AW-1:0];
               buf_wdata = sweep_val_ff;
            end
            if (init_ff && 32'(sweep_ff) < SCR_CELLS) begin
               scr_we    = 1'b1;
               scr_waddr = sweep_ff[SCR_AW-1:0];
               scr_wdata = '0;
            end
            if (sweep_ff == SWEEP_W'(SWEEP_LEN - 1)) begin
               state_in = init_ff ? ST_FETCH : ST_DONE;
               init_in  = 1'b0;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_FETCH: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               value_in = '0;
               unique case (q_head.kind)
                  KIND_PUT:       state_in = ST_PUT;
                  KIND_BACKSPACE: state_in = ST_BS_START;
                  KIND_CLEAR: begin
                     sweep_in     = '0;
                     sweep_val_in = blank_cell;
                     cur_row_in   = '0;
                     cur_col_in   = '0;
                     fvr_in       = '0;
                     base_in      = '0;
                     dirty_in     = '1;
                     state_in     = ST_SWEEP;
                  end
                  KIND_READ:      state_in = ST_READ_WAIT;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_PUT: begin
            if (!is_newline) begin
               buf_we    = 1'b1;
               buf_waddr = {phys_row(cur_row_ff, base_ff), cur_col_ff};
               buf_wdata = make_cell(bg_ff, fg_ff, cmd_ff.char_code);
            end
            cur_row_in  = line_x[ROW_W-1:0];
            cur_col_in  = advance ? '0 : cur_col_ff + 1'b1;
            fvr_in      = follow ? fvr_follow[ROW_W-1:0] : fvr1;
            dirty_in    = (shift || follow) ? '1 : (dirty_ff | put_mask);
            pend_in     = put_pend;
            ref_row_in  = '0;
            scr_base_in = '0;
            if (shift) begin
               base_in    = (base_ff == ROW_W'(BUFFER_ROWS - 1)) ? '0 : base_ff + 1'b1;
               src_row_in = base_ff;
               col_in     = '0;
               state_in   = ST_SCROLL;
            end else begin
               state_in = put_pend ? ST_REF_ROW : ST_DONE;
            end
         end
         ST_SCROLL: begin
            buf_we    = 1'b1;
            buf_waddr = {src_row_ff, col_ff};
            buf_wdata = blank_cell;
            if (col_ff == COL_W'(SCREEN_COLUMNS - 1)) begin
               state_in = ST_REF_ROW;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_BS_START: begin
            if (cur_zero) begin
               state_in = ST_DONE;
            end else begin
               old_row_in = cur_row_ff;
               cur_row_in = dec_row;
               cur_col_in = dec_col;
               cnt_in     = '0;
               state_in   = ST_BS_LOOP;
            end
         end
         ST_BS_LOOP: begin
            buf_we    = 1'b1;
            buf_waddr = {phys_row(cur_row_ff, base_ff), cur_col_ff};
            buf_wdata = blank_cell;
            dirty_in  = dirty_ff | cur_mask;
            pend_in   = pend_ff || (|cur_mask);
            if (!cur_zero && cnt_ff < cmd_ff.erase_count) begin
               cur_row_in = dec_row;
               cur_col_in = dec_col;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = ST_BS_END;
            end
         end
         ST_BS_END: begin
            dirty_in    = dirty_ff | end_mask;
            pend_in     = end_pend;
            ref_row_in  = '0;
            scr_base_in = '0;
            state_in    = end_pend ? ST_REF_ROW : ST_DONE;
         end
         ST_REF_ROW: begin
            if (dirty_ff[ref_row_ff]) begin
               dirty_in[ref_row_ff] = 1'b0;
               src_row_in = phys_row(src_x[ROW_W-1:0], base_ff);
               src_ok_in  = src_x < LX_W'(BUFFER_ROWS);
               col_in     = '0;
               state_in   = ST_REF_COPY;
            end else if (ref_last) begin
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end else begin
               ref_row_in  = ref_row_ff + 1'b1;
               scr_base_in = scr_base_ff + SCR_AW'(SCREEN_COLUMNS);
            end
         end
         ST_REF_COPY: begin
            copy_en_in = 1'b1;
            if (col_ff == COL_W'(SCREEN_COLUMNS - 1)) begin
               if (ref_last) begin
                  pend_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  ref_row_in  = ref_row_ff + 1'b1;
                  scr_base_in = scr_base_ff + SCR_AW'(SCREEN_COLUMNS);
                  state_in    = ST_REF_ROW;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_READ_WAIT: begin
            value_in = scr_rdata_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cursor_in = CURSOR_W'(int'(cur_row_ff) * SCREEN_COLUMNS
                                         + int'(cur_col_ff));
               rsp_view_in   = VIEW_W'(fvr_ff);
               rsp_cell_in   = value_ff;
               state_in      = ST_FETCH;
            end
         end
         default: state_in = ST_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         fg_ff        <= RESET_FG;
         bg_ff        <= RESET_BG;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         fvr_ff       <= '0;
         base_ff      <= '0;
         dirty_ff     <= '1;
         pend_ff      <= 1'b0;
         init_ff      <= 1'b1;
         sweep_ff     <= '0;
         sweep_val_ff <= make_cell(RESET_BG, RESET_FG, SPACE_CODE);
         rsp_valid_ff <= 1'b0;
         copy_en_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         fvr_ff       <= fvr_in;
         base_ff      <= base_in;
         dirty_ff     <= dirty_in;
         pend_ff      <= pend_in;
         init_ff      <= init_in;
         sweep_ff     <= sweep_in;
         sweep_val_ff <= sweep_val_in;
         rsp_valid_ff <= rsp_valid_in;
         copy_en_ff   <= copy_en_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      old_row_ff    <= old_row_in;
      cnt_ff        <= cnt_in;
      col_ff        <= col_in;
      src_row_ff    <= src_row_in;
      src_ok_ff     <= src_ok_in;
      ref_row_ff    <= ref_row_in;
      scr_base_ff   <= scr_base_in;
      value_ff      <= value_in;
      copy_addr_ff  <= copy_addr_in;
      copy_zero_ff  <= copy_zero_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_view_ff   <= rsp_view_in;
      rsp_cell_ff   <= rsp_cell_in;
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      buf_rdata_ff <= buf_mem[buf_raddr];
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_waddr] <= scr_wdata;
      end
      scr_rdata_ff <= scr_mem[scr_raddr];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_cursor_ff;
   assign rsp_view_offset     = rsp_view_ff;
   assign rsp_cell_value      = rsp_cell_ff;

endmodule
